FILE: sv/mmpa_pkg.sv
package mmpa_pkg;

    // Store geometry
    localparam int MAX_DIM   = 32;
    localparam int DEPTH     = MAX_DIM * MAX_DIM;
    localparam int AW        = $clog2(DEPTH);
    localparam int DW        = $clog2(MAX_DIM + 1);

    // Fixed field widths
    localparam int ELEM_W    = 16;
    localparam int ACC_W     = 32;
    localparam int CFG_W     = 6;
    localparam int CFG_IDX_W = 2;
    localparam int OP_W      = 3;
    localparam int IDX_W     = 5;

    // Command codes
    localparam logic [OP_W-1:0] OP_WR_A    = 3'd0;
    localparam logic [OP_W-1:0] OP_WR_B    = 3'd1;
    localparam logic [OP_W-1:0] OP_CLR_C   = 3'd2;
    localparam logic [OP_W-1:0] OP_COMPUTE = 3'd3;
    localparam logic [OP_W-1:0] OP_RD_C    = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_B   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_K_START  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_K_END    = 2'd3;

    // Result kinds
    localparam logic KIND_RDATA = 1'b0;
    localparam logic KIND_DONE  = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_DOT,
        S_DRAIN,
        S_DONE
    } t_state;

    // Decoded input item
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [AW-1:0]   addr;
        logic            ok;
    } t_cmd;

    // Saturated sizes
    typedef struct packed {
        logic [DW-1:0] rows;
        logic [DW-1:0] cols;
        logic [DW-1:0] k_start;
        logic [DW-1:0] k_end;
    } t_dims;

    // Sequencer controls towards stores, MAC unit and output register
    typedef struct packed {
        logic          a_re;
        logic [AW-1:0] a_addr;
        logic [AW-1:0] b_addr;
        logic          c_re;
        logic [AW-1:0] c_raddr;
        logic          c_we;
        logic [AW-1:0] c_waddr;
        logic          c_wzero;
        logic          mac_en;
        logic          mac_acc;
        logic          mac_clr;
        logic          out_load;
        logic          out_kind;
        logic          out_zero;
    } t_ctl;

    function automatic logic [DW-1:0] sat_dim(input logic [CFG_W-1:0] v);
        if (32'(v) > 32'(MAX_DIM)) begin
            return DW'(MAX_DIM);
        end
        return DW'(v);
    endfunction

    function automatic logic [AW-1:0] mat_addr(input logic [31:0] r, input logic [31:0] c);
        return AW'(r * 32'(MAX_DIM) + c);
    endfunction

endpackage

FILE: sv/mmpa_mac.sv
module mmpa_mac
    import mmpa_pkg::*;
(
    input  logic                     i_clk,
    input  logic signed [ELEM_W-1:0] i_a,
    input  logic signed [ELEM_W-1:0] i_b,
    input  logic                     i_en,
    input  logic                     i_acc,
    input  logic                     i_clr,
    input  logic        [ACC_W-1:0]  i_c_old,
    output logic        [ACC_W-1:0]  o_sum
);

    logic signed [ACC_W-1:0] r_prod;
    logic        [ACC_W-1:0] r_acc;

    // Product stage, then wrapping accumulate
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= ACC_W'(i_a) * ACC_W'(i_b);
        end
        if (i_clr) begin
            r_acc <= '0;
        end else if (i_acc) begin
            r_acc <= r_acc + $unsigned(r_prod);
        end
    end

    // Old accumulator element plus partial dot product
    assign o_sum = i_c_old + r_acc;

endmodule

FILE: sv/mmpa_seq.sv
module mmpa_seq
    import mmpa_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_start,
    input  t_cmd   i_cmd,
    input  t_dims  i_dims,
    input  logic   i_out_free,
    output logic   o_busy,
    output t_state o_state,
    output t_ctl   o_ctl
);

    t_state        r_state, n_state;
    logic [DW-1:0] r_i, n_i;
    logic [DW-1:0] r_j, n_j;
    logic [DW-1:0] r_k, n_k;
    logic [AW-1:0] r_clr, n_clr;
    logic          r_v1, n_v1;
    logic          r_v2, n_v2;
    logic          r_rd_ok, n_rd_ok;
    logic [DW-1:0] w_k_inc;
    logic          w_empty;

    assign w_k_inc = r_k + DW'(1);
    assign w_empty = (i_dims.rows == '0) || (i_dims.cols == '0) ||
                     (i_dims.k_start >= i_dims.k_end);

    // State and loop counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
            r_clr   <= '0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_rd_ok <= 1'b0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
            r_clr   <= n_clr;
            r_v1    <= n_v1;
            r_v2    <= n_v2;
            r_rd_ok <= n_rd_ok;
        end
    end

    // Next state and controls
    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        n_clr   = r_clr;
        n_rd_ok = r_rd_ok;
        n_v1    = 1'b0;
        n_v2    = r_v1;
        o_ctl          = '0;
        o_ctl.a_addr   = mat_addr(32'(r_i), 32'(r_k));
        o_ctl.b_addr   = mat_addr(32'(r_k), 32'(r_j));
        o_ctl.c_raddr  = mat_addr(32'(r_i), 32'(r_j));
        o_ctl.c_waddr  = mat_addr(32'(r_i), 32'(r_j));
        o_ctl.mac_en   = r_v1;
        o_ctl.mac_acc  = r_v2;
        unique case (r_state)
            S_CLEAR: begin
                // one zero write per cycle over the whole accumulator
                o_ctl.c_we    = 1'b1;
                o_ctl.c_wzero = 1'b1;
                o_ctl.c_waddr = r_clr;
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + AW'(1);
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    unique case (i_cmd.op)
                        OP_CLR_C: begin
                            n_clr   = '0;
                            n_state = S_CLEAR;
                        end
                        OP_COMPUTE: begin
                            n_i           = '0;
                            n_j           = '0;
                            n_k           = i_dims.k_start;
                            o_ctl.mac_clr = 1'b1;
                            n_state       = w_empty ? S_DONE : S_DOT;
                        end
                        OP_RD_C: begin
                            o_ctl.c_re    = 1'b1;
                            o_ctl.c_raddr = i_cmd.addr;
                            n_rd_ok       = i_cmd.ok;
                            n_state       = S_READ;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_READ: begin
                if (i_out_free) begin
                    o_ctl.out_load = 1'b1;
                    o_ctl.out_kind = KIND_RDATA;
                    o_ctl.out_zero = !r_rd_ok;
                    n_state        = S_IDLE;
                end
            end
            S_DOT: begin
                // issue one A/B operand pair per cycle; old C read on first step
                o_ctl.a_re = 1'b1;
                n_v1       = 1'b1;
                if (r_k == i_dims.k_start) begin
                    o_ctl.c_re = 1'b1;
                end
                if (w_k_inc == i_dims.k_end) begin
                    n_state = S_DRAIN;
                end else begin
                    n_k = w_k_inc;
                end
            end
            S_DRAIN: begin
                // pipeline empty: write back and step to next position
                if (!r_v1 && !r_v2) begin
                    o_ctl.c_we    = 1'b1;
                    o_ctl.mac_clr = 1'b1;
                    n_k           = i_dims.k_start;
                    n_state       = S_DOT;
                    if (DW'(r_j + DW'(1)) == i_dims.cols) begin
                        n_j = '0;
                        if (DW'(r_i + DW'(1)) == i_dims.rows) begin
                            n_state = S_DONE;
                        end else begin
                            n_i = r_i + DW'(1);
                        end
                    end else begin
                        n_j = r_j + DW'(1);
                    end
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_ctl.out_load = 1'b1;
                    o_ctl.out_kind = KIND_DONE;
                    o_ctl.out_zero = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_state = r_state;

endmodule

FILE: sv/matrix_multiply_partial_accumulate.sv
// Channel   Handshake                     Payload
// input     i_in_valid / o_in_stall       i_op, i_row, i_col, i_value
// result    o_out_valid / i_out_stall     o_kind, o_data
// config    i_cfg_we                      i_cfg_idx, i_cfg_data
//
// Element writes and unused op codes are taken while idle; a read of C holds
// o_in_stall until its result is loaded. A compute uses one shared multiply-
// accumulate unit fed by the single read ports of the A and B stores.
// A clear, and reset itself, sweep the C store at one entry a cycle over all
// MAX_DIM^2 (1024) entries, while o_in_stall stays high.
// A waiting result in the output register does not hold up element writes.
module matrix_multiply_partial_accumulate
    import mmpa_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic        [OP_W-1:0]   i_op,
    input  logic        [IDX_W-1:0]  i_row,
    input  logic        [IDX_W-1:0]  i_col,
    input  logic signed [ELEM_W-1:0] i_value,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic                     o_kind,
    output logic signed [ACC_W-1:0]  o_data,
    input  logic                     i_cfg_we,
    input  logic        [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic        [CFG_W-1:0]  i_cfg_data
);

    logic [CFG_W-1:0]  r_rows_a, r_cols_b, r_k_start, r_k_end;
    logic [ELEM_W-1:0] r_mem_a [DEPTH];
    logic [ELEM_W-1:0] r_mem_b [DEPTH];
    logic [ACC_W-1:0]  r_mem_c [DEPTH];
    logic [ELEM_W-1:0] r_a_rd, r_b_rd;
    logic [ACC_W-1:0]  r_c_rd;
    logic              r_out_valid;
    logic              r_out_kind;
    logic [ACC_W-1:0]  r_out_data;
    logic              w_in_acc;
    logic              w_busy;
    logic              w_out_free;
    logic [ACC_W-1:0]  w_sum;
    t_cmd              w_cmd;
    t_dims             w_dims;
    t_ctl              w_ctl;
    t_state            w_state;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_a  <= CFG_W'(32);
            r_cols_b  <= CFG_W'(32);
            r_k_start <= '0;
            r_k_end   <= CFG_W'(32);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ROWS_A:  r_rows_a  <= i_cfg_data;
                CFG_COLS_B:  r_cols_b  <= i_cfg_data;
                CFG_K_START: r_k_start <= i_cfg_data;
                CFG_K_END:   r_k_end   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign w_dims.rows    = sat_dim(r_rows_a);
    assign w_dims.cols    = sat_dim(r_cols_b);
    assign w_dims.k_start = sat_dim(r_k_start);
    assign w_dims.k_end   = sat_dim(r_k_end);

    // Input decode
    assign o_in_stall = w_busy;
    assign w_in_acc   = i_in_valid && !w_busy;
    assign w_cmd.op   = i_op;
    assign w_cmd.addr = mat_addr(32'(i_row), 32'(i_col));
    assign w_cmd.ok   = (32'(i_row) < 32'(MAX_DIM)) && (32'(i_col) < 32'(MAX_DIM));

    mmpa_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_in_acc),
        .i_cmd      (w_cmd),
        .i_dims     (w_dims),
        .i_out_free (w_out_free),
        .o_busy     (w_busy),
        .o_state    (w_state),
        .o_ctl      (w_ctl)
    );

    // Operand stores
    always_ff @(posedge i_clk) begin
        if (w_in_acc && (i_op == OP_WR_A) && w_cmd.ok) begin
            r_mem_a[w_cmd.addr] <= i_value;
        end
        if (w_ctl.a_re) begin
            r_a_rd <= r_mem_a[w_ctl.a_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && (i_op == OP_WR_B) && w_cmd.ok) begin
            r_mem_b[w_cmd.addr] <= i_value;
        end
        if (w_ctl.a_re) begin
            r_b_rd <= r_mem_b[w_ctl.b_addr];
        end
    end

    // Accumulator store
    always_ff @(posedge i_clk) begin
        if (w_ctl.c_we) begin
            r_mem_c[w_ctl.c_waddr] <= w_ctl.c_wzero ? '0 : w_sum;
        end
        if (w_ctl.c_re) begin
            r_c_rd <= r_mem_c[w_ctl.c_raddr];
        end
    end

    mmpa_mac u_mac (
        .i_clk   (i_clk),
        .i_a     ($signed(r_a_rd)),
        .i_b     ($signed(r_b_rd)),
        .i_en    (w_ctl.mac_en),
        .i_acc   (w_ctl.mac_acc),
        .i_clr   (w_ctl.mac_clr),
        .i_c_old (r_c_rd),
        .o_sum   (w_sum)
    );

    // Output register
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.out_load) begin
            r_out_kind <= w_ctl.out_kind;
            r_out_data <= w_ctl.out_zero ? '0 : r_c_rd;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_out_kind;
    assign o_data      = $signed(r_out_data);

    // Checks
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.out_load |-> (!r_out_valid || !i_out_stall))
        else $error("result loaded over a waiting result");

    a_compute_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_op == OP_COMPUTE)) |=> o_in_stall)
        else $error("compute accepted without going busy");

    a_clear_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_op == OP_CLR_C)) |=> (o_in_stall && (w_state == S_CLEAR)))
        else $error("clear accepted without sweeping");

    a_done_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_kind == KIND_DONE)) |-> (o_data == '0))
        else $error("done result carries data");

endmodule
